[sv/hssk_pkg.sv]
// package for the string-key heap sort: widths, defaults and shared types
`default_nettype none
package hssk_pkg;
    localparam int MaxRecordsDefault = 16;
    localparam int KeyWordsDefault   = 7;
    localparam int WordWidth         = 64;
    localparam int NumWidth          = 6;

    // compare results
    typedef enum logic [1:0] {
        CMP_LT = 2'd0,
        CMP_EQ = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

    // datapath commands from the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_ORDER,
        OP_LOAD_HELD,
        OP_CMP_CHILDREN,
        OP_CMP_HELD,
        OP_MOVE_UP,
        OP_STORE_HELD,
        OP_SWAP_TOP,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t      op;
        logic [6:0] a;     // 1-based heap position
        logic [6:0] b;     // 1-based heap position
    } cmd_t;

    typedef struct packed {
        logic done;        // command finished
        cmp_t cmp;         // result of a compare command
    } status_t;
endpackage
`default_nettype wire

[sv/hssk_if.sv]
// valid/ready channel interface carrying one word per handshake
`default_nettype none
interface hssk_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/hssk_datapath.sv]
// datapath: key memory, heap order registers and byte-serial compare unit
`default_nettype none
module hssk_datapath #(
    parameter int MAX_RECORDS = hssk_pkg::MaxRecordsDefault,
    parameter int KEY_WORDS   = hssk_pkg::KeyWordsDefault
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // key write port
    input  wire logic                  key_we,
    input  wire logic [$clog2(MAX_RECORDS*KEY_WORDS)-1:0] key_waddr,
    input  wire logic [hssk_pkg::WordWidth-1:0] key_wdata,
    // control
    input  wire hssk_pkg::cmd_t        cmd,
    input  wire logic                  cmd_valid,
    output hssk_pkg::status_t          status,
    output logic [hssk_pkg::NumWidth-1:0] emit_num
);
    localparam int Depth = MAX_RECORDS * KEY_WORDS;
    localparam int AW    = $clog2(Depth);
    localparam int IW    = $clog2(MAX_RECORDS);
    localparam int WW    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    typedef enum logic [2:0] {
        D_IDLE,
        D_RD,
        D_WAIT,
        D_BYTES,
        D_DONE
    } dstate_t;

    logic [hssk_pkg::WordWidth-1:0] key_mem [Depth];
    logic [hssk_pkg::WordWidth-1:0] rd_x_reg;
    logic [hssk_pkg::WordWidth-1:0] rd_y_reg;
    logic [AW-1:0] rx_addr;
    logic [AW-1:0] ry_addr;

    logic [hssk_pkg::NumWidth-1:0] order_reg [MAX_RECORDS];
    logic [hssk_pkg::NumWidth-1:0] held_reg;

    dstate_t    dstate_reg;
    logic [WW-1:0] word_reg;
    logic [2:0] byte_reg;
    logic [hssk_pkg::NumWidth-1:0] ra_reg;
    logic [hssk_pkg::NumWidth-1:0] rb_reg;
    hssk_pkg::cmp_t cmp_reg;
    logic done_reg;
    logic [hssk_pkg::NumWidth-1:0] emit_reg;

    logic [7:0] ca;
    logic [7:0] cb;
    logic [IW-1:0] ia;
    logic [IW-1:0] ib;

    assign ia = IW'(cmd.a - 7'd1);
    assign ib = IW'(cmd.b - 7'd1);
    assign ca = rd_x_reg[8*(7 - byte_reg) +: 8];
    assign cb = rd_y_reg[8*(7 - byte_reg) +: 8];
    assign rx_addr = AW'(ra_reg * KEY_WORDS + word_reg);
    assign ry_addr = AW'(rb_reg * KEY_WORDS + word_reg);

    // key memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        rd_x_reg <= key_mem[rx_addr];
        rd_y_reg <= key_mem[ry_addr];
    end

    // heap order and command execution
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            done_reg   <= 1'b0;
            cmp_reg    <= hssk_pkg::CMP_EQ;
            word_reg   <= '0;
            byte_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (dstate_reg)
                D_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        unique case (cmd.op)
                            hssk_pkg::OP_INIT_ORDER:
                            begin
                                for (int i = 0; i < MAX_RECORDS; i++)
                                begin
                                    order_reg[i] <= hssk_pkg::NumWidth'(i);
                                end
                                done_reg <= 1'b1;
                            end
                            hssk_pkg::OP_LOAD_HELD:
                            begin
                                held_reg <= order_reg[ia];
                                done_reg <= 1'b1;
                            end
                            hssk_pkg::OP_CMP_CHILDREN:
                            begin
                                ra_reg     <= order_reg[ia];
                                rb_reg     <= order_reg[ib];
                                word_reg   <= '0;
                                byte_reg   <= '0;
                                dstate_reg <= D_RD;
                            end
                            hssk_pkg::OP_CMP_HELD:
                            begin
                                ra_reg     <= held_reg;
                                rb_reg     <= order_reg[ib];
                                word_reg   <= '0;
                                byte_reg   <= '0;
                                dstate_reg <= D_RD;
                            end
                            hssk_pkg::OP_MOVE_UP:
                            begin
                                order_reg[ia] <= order_reg[ib];
                                done_reg <= 1'b1;
                            end
                            hssk_pkg::OP_STORE_HELD:
                            begin
                                order_reg[ia] <= held_reg;
                                done_reg <= 1'b1;
                            end
                            hssk_pkg::OP_SWAP_TOP:
                            begin
                                order_reg[0]  <= order_reg[ib];
                                order_reg[ib] <= order_reg[0];
                                done_reg <= 1'b1;
                            end
                            hssk_pkg::OP_EMIT:
                            begin
                                emit_reg <= order_reg[ia];
                                done_reg <= 1'b1;
                            end
                            default:
                            begin
                                done_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                // address presented, data arrives next cycle
                D_RD:
                begin
                    dstate_reg <= D_WAIT;
                end
                D_WAIT:
                begin
                    dstate_reg <= D_BYTES;
                end
                // one byte a cycle, strcmp order
                D_BYTES:
                begin
                    if (ca != cb)
                    begin
                        cmp_reg    <= (ca < cb) ? hssk_pkg::CMP_LT : hssk_pkg::CMP_GT;
                        dstate_reg <= D_DONE;
                    end
                    else if (ca == 8'd0)
                    begin
                        cmp_reg    <= hssk_pkg::CMP_EQ;
                        dstate_reg <= D_DONE;
                    end
                    else if (byte_reg == 3'd7)
                    begin
                        byte_reg <= '0;
                        if (32'(word_reg) == KEY_WORDS - 1)
                        begin
                            cmp_reg    <= hssk_pkg::CMP_EQ;
                            dstate_reg <= D_DONE;
                        end
                        else
                        begin
                            word_reg   <= word_reg + 1'b1;
                            dstate_reg <= D_RD;
                        end
                    end
                    else
                    begin
                        byte_reg <= byte_reg + 3'd1;
                    end
                end
                D_DONE:
                begin
                    done_reg   <= 1'b1;
                    dstate_reg <= D_IDLE;
                end
                default:
                begin
                    dstate_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign status.done = done_reg;
    assign status.cmp  = cmp_reg;
    assign emit_num    = emit_reg;
endmodule
`default_nettype wire

[sv/hssk_ctrl.sv]
// controller: loading, heap build, sort-down and result sequencing
`default_nettype none
module hssk_ctrl #(
    parameter int MAX_RECORDS = hssk_pkg::MaxRecordsDefault,
    parameter int KEY_WORDS   = hssk_pkg::KeyWordsDefault
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [hssk_pkg::WordWidth-1:0] in_key_word,
    input  wire logic                  in_word_last,
    input  wire logic                  in_record_last,
    output logic                       key_we,
    output logic [$clog2(MAX_RECORDS*KEY_WORDS)-1:0] key_waddr,
    output logic [hssk_pkg::WordWidth-1:0] key_wdata,
    output hssk_pkg::cmd_t             cmd,
    output logic                       cmd_valid,
    input  wire hssk_pkg::status_t     status,
    input  wire logic [hssk_pkg::NumWidth-1:0] emit_num,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [hssk_pkg::NumWidth-1:0] out_num,
    output logic                       out_last,
    output logic                       out_overflow
);
    localparam int AW = $clog2(MAX_RECORDS*KEY_WORDS);
    localparam logic [6:0] MaxRec = 7'(MAX_RECORDS);
    localparam logic [3:0] KeyW   = 4'(KEY_WORDS);

    typedef enum logic [3:0] {
        S_LOAD,
        S_PAD,
        S_INIT,
        S_BUILD,
        S_SWAP,
        S_SIFT_LD,
        S_SIFT_TEST,
        S_SIFT_CCH,
        S_SIFT_CHELD,
        S_SIFT_MOVE,
        S_SIFT_STORE,
        S_EMIT,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] count_reg, count_next;
    logic [3:0] wpos_reg, wpos_next;
    logic       ovf_reg, ovf_next;
    logic       sort_pend_reg, sort_pend_next;
    logic [6:0] top_reg, top_next;     // sift start / build index
    logic [6:0] n_reg, n_next;         // heap size for sift
    logic [7:0] c_reg, c_next;         // child position
    logic [6:0] i_reg, i_next;         // sort-down / emit index
    logic       build_reg, build_next; // in build phase
    logic       issued_reg, issued_next;
    logic       ov_reg, ov_next;
    logic [hssk_pkg::NumWidth-1:0] onum_reg, onum_next;
    logic       olast_reg, olast_next;
    logic       oovf_reg, oovf_next;

    logic accept;
    logic store_ok;

    assign in_ready = (state_reg == S_LOAD);
    assign accept   = in_valid && in_ready;
    assign store_ok = (count_reg < MaxRec) && (wpos_reg < KeyW);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        wpos_next      = wpos_reg;
        ovf_next       = ovf_reg;
        sort_pend_next = sort_pend_reg;
        top_next       = top_reg;
        n_next         = n_reg;
        c_next         = c_reg;
        i_next         = i_reg;
        build_next     = build_reg;
        issued_next    = 1'b0;
        ov_next        = ov_reg;
        onum_next      = onum_reg;
        olast_next     = olast_reg;
        oovf_next      = oovf_reg;
        key_we         = 1'b0;
        key_waddr      = AW'(count_reg * KEY_WORDS + wpos_reg);
        key_wdata      = in_key_word;
        cmd.op         = hssk_pkg::OP_NONE;
        cmd.a          = '0;
        cmd.b          = '0;
        cmd_valid      = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            // one key word per handshake
            S_LOAD:
            begin
                if (accept)
                begin
                    key_we = store_ok;
                    if (wpos_reg < KeyW)
                    begin
                        wpos_next = wpos_reg + 4'd1;
                    end
                    if (in_word_last || in_record_last)
                    begin
                        sort_pend_next = in_record_last;
                        if (count_reg < MaxRec)
                        begin
                            state_next = S_PAD;
                        end
                        else
                        begin
                            ovf_next  = 1'b1;
                            wpos_next = '0;
                            if (in_record_last)
                            begin
                                state_next = S_INIT;
                            end
                        end
                    end
                end
            end
            // zero the unsent words of a short key
            S_PAD:
            begin
                if (wpos_reg < KeyW)
                begin
                    key_we    = 1'b1;
                    key_wdata = '0;
                    wpos_next = wpos_reg + 4'd1;
                end
                else
                begin
                    wpos_next  = '0;
                    count_next = count_reg + 7'd1;
                    state_next = sort_pend_reg ? S_INIT : S_LOAD;
                end
            end
            S_INIT:
            begin
                cmd.op    = hssk_pkg::OP_INIT_ORDER;
                cmd_valid = !issued_reg;
                issued_next = !status.done;
                if (status.done)
                begin
                    build_next = 1'b1;
                    top_next   = count_reg >> 1;
                    n_next     = count_reg;
                    state_next = S_BUILD;
                end
            end
            // heap build: sift each internal node
            S_BUILD:
            begin
                if (top_reg == 7'd0)
                begin
                    build_next = 1'b0;
                    i_next     = count_reg - 7'd1;
                    state_next = (count_reg > 7'd1) ? S_SWAP : S_EMIT;
                    if (count_reg <= 7'd1)
                    begin
                        i_next = '0;
                    end
                end
                else
                begin
                    state_next = S_SIFT_LD;
                end
            end
            S_SWAP:
            begin
                cmd.op    = hssk_pkg::OP_SWAP_TOP;
                cmd.b     = i_reg + 7'd1;
                cmd_valid = !issued_reg;
                issued_next = !status.done;
                if (status.done)
                begin
                    top_next   = 7'd1;
                    n_next     = i_reg;
                    state_next = S_SIFT_LD;
                end
            end
            S_SIFT_LD:
            begin
                cmd.op    = hssk_pkg::OP_LOAD_HELD;
                cmd.a     = top_reg;
                cmd_valid = !issued_reg;
                issued_next = !status.done;
                if (status.done)
                begin
                    c_next     = {top_reg, 1'b0};
                    state_next = S_SIFT_TEST;
                end
            end
            S_SIFT_TEST:
            begin
                if (c_reg <= {1'b0, n_reg})
                begin
                    state_next = (c_reg < {1'b0, n_reg}) ? S_SIFT_CCH : S_SIFT_CHELD;
                end
                else
                begin
                    state_next = S_SIFT_STORE;
                end
            end
            S_SIFT_CCH:
            begin
                cmd.op    = hssk_pkg::OP_CMP_CHILDREN;
                cmd.a     = c_reg[6:0];
                cmd.b     = c_reg[6:0] + 7'd1;
                cmd_valid = !issued_reg;
                issued_next = !status.done;
                if (status.done)
                begin
                    if (status.cmp == hssk_pkg::CMP_LT)
                    begin
                        c_next = c_reg + 8'd1;
                    end
                    state_next = S_SIFT_CHELD;
                end
            end
            S_SIFT_CHELD:
            begin
                cmd.op    = hssk_pkg::OP_CMP_HELD;
                cmd.b     = c_reg[6:0];
                cmd_valid = !issued_reg;
                issued_next = !status.done;
                if (status.done)
                begin
                    state_next = (status.cmp == hssk_pkg::CMP_GT) ? S_SIFT_STORE
                                                                  : S_SIFT_MOVE;
                end
            end
            S_SIFT_MOVE:
            begin
                cmd.op    = hssk_pkg::OP_MOVE_UP;
                cmd.a     = c_reg[7:1];
                cmd.b     = c_reg[6:0];
                cmd_valid = !issued_reg;
                issued_next = !status.done;
                if (status.done)
                begin
                    c_next     = {c_reg[6:0], 1'b0};
                    state_next = S_SIFT_TEST;
                end
            end
            S_SIFT_STORE:
            begin
                cmd.op    = hssk_pkg::OP_STORE_HELD;
                cmd.a     = c_reg[7:1];
                cmd_valid = !issued_reg;
                issued_next = !status.done;
                if (status.done)
                begin
                    if (build_reg)
                    begin
                        top_next   = top_reg - 7'd1;
                        state_next = S_BUILD;
                    end
                    else if (i_reg > 7'd1)
                    begin
                        i_next     = i_reg - 7'd1;
                        state_next = S_SWAP;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            // fetch the record number at the next sorted position
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.op    = hssk_pkg::OP_EMIT;
                    cmd.a     = i_reg + 7'd1;
                    cmd_valid = !issued_reg;
                    issued_next = !status.done;
                    if (status.done)
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    issued_next = issued_reg;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    onum_next  = emit_num;
                    olast_next = (i_reg + 7'd1 == count_reg);
                    oovf_next  = ovf_reg;
                    if (i_reg + 7'd1 == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 7'd1;
                        state_next = S_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            wpos_reg      <= '0;
            ovf_reg       <= 1'b0;
            sort_pend_reg <= 1'b0;
            top_reg       <= '0;
            n_reg         <= '0;
            c_reg         <= '0;
            i_reg         <= '0;
            build_reg     <= 1'b0;
            issued_reg    <= 1'b0;
            ov_reg        <= 1'b0;
            onum_reg      <= '0;
            olast_reg     <= 1'b0;
            oovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wpos_reg      <= wpos_next;
            ovf_reg       <= ovf_next;
            sort_pend_reg <= sort_pend_next;
            top_reg       <= top_next;
            n_reg         <= n_next;
            c_reg         <= c_next;
            i_reg         <= i_next;
            build_reg     <= build_next;
            issued_reg    <= issued_next;
            ov_reg        <= ov_next;
            onum_reg      <= onum_next;
            olast_reg     <= olast_next;
            oovf_reg      <= oovf_next;
        end
    end

    assign out_valid    = ov_reg;
    assign out_num      = onum_reg;
    assign out_last     = olast_reg;
    assign out_overflow = oovf_reg;
endmodule
`default_nettype wire

[sv/heap_sort_string_keys_core.sv]
// top level: heap sort of streamed text keys, returning load-order record numbers
// Loading takes one key word per cycle while in_ready is high; after each key the
// core zero-pads the unsent words and closes the record. On the word with record_last
// the core heap-sorts the batch with a max-heap and a byte-serial strcmp-style compare
// on a dual-read key memory: each compare fetches one word of each key at a time and
// examines it byte by byte, so sorting n records takes roughly 2 n log2 n compares.
// Results are then fetched in order and registered. Input is not taken while sorting
// or emitting; records beyond MAX_RECORDS are dropped and flagged on every result.
`default_nettype none
module heap_sort_string_keys_core #(
    parameter int MAX_RECORDS = hssk_pkg::MaxRecordsDefault,
    parameter int KEY_WORDS   = hssk_pkg::KeyWordsDefault
) (
    input wire logic clk,
    input wire logic rst_n,
    hssk_if.sink     in_ch,
    hssk_if.source   out_ch
);
    logic key_we;
    logic [$clog2(MAX_RECORDS*KEY_WORDS)-1:0] key_waddr;
    logic [hssk_pkg::WordWidth-1:0] key_wdata;
    hssk_pkg::cmd_t    cmd;
    logic              cmd_valid;
    hssk_pkg::status_t status;
    logic [hssk_pkg::NumWidth-1:0] emit_num;

    // controller
    hssk_ctrl #(
        .MAX_RECORDS(MAX_RECORDS),
        .KEY_WORDS  (KEY_WORDS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_ready      (in_ch.ready),
        .in_key_word   (in_ch.data.key_word),
        .in_word_last  (in_ch.data.word_last),
        .in_record_last(in_ch.data.record_last),
        .key_we        (key_we),
        .key_waddr     (key_waddr),
        .key_wdata     (key_wdata),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .status        (status),
        .emit_num      (emit_num),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_num       (out_ch.data.record_number),
        .out_last      (out_ch.data.last),
        .out_overflow  (out_ch.data.overflow)
    );

    // datapath
    hssk_datapath #(
        .MAX_RECORDS(MAX_RECORDS),
        .KEY_WORDS  (KEY_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_we   (key_we),
        .key_waddr(key_waddr),
        .key_wdata(key_wdata),
        .cmd      (cmd),
        .cmd_valid(cmd_valid),
        .status   (status),
        .emit_num (emit_num)
    );
endmodule
`default_nettype wire

[tb/sv/heap_sort_string_keys_core_tb.sv]
// testbench for the string-key heap sort core: directed table, random batches, live prediction
`default_nettype none
module heap_sort_string_keys_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hssk_pkg::*;

    localparam int MaxRec   = MaxRecordsDefault;
    localparam int KeyWords = KeyWordsDefault;
    localparam int NumDirected = 20;
    localparam int NumRandom   = 320;

    typedef struct packed {
        logic [WordWidth-1:0] key_word;
        logic                 word_last;
        logic                 record_last;
    } key_in_t;

    typedef struct packed {
        logic [NumWidth-1:0] record_number;
        logic                last;
        logic                overflow;
    } rank_out_t;

    typedef struct {
        logic [WordWidth-1:0] key_word;
        bit                   word_last;
        bit                   record_last;
        bit                   typed;      // expectation written in by hand
        rank_out_t            typed_res;
    } row_t;

    logic clk;
    logic rst_n;

    hssk_if #(.payload_t(key_in_t))   in_ch ();
    hssk_if #(.payload_t(rank_out_t)) out_ch ();

    heap_sort_string_keys_core #(
        .MAX_RECORDS(MaxRec),
        .KEY_WORDS  (KeyWords)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // shadow copy of the sorter state
    logic [WordWidth-1:0] shadow_keys [MaxRec*KeyWords];
    logic [NumWidth-1:0]  shadow_heap [MaxRec];
    int unsigned          shadow_count;
    int unsigned          shadow_pos;
    bit                   shadow_ovf;

    rank_out_t rank_q [$];
    int        error_count;
    int        send_idle;
    int        recv_idle;
    row_t      dir_rows [NumDirected];

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog
    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report(input string what, input rank_out_t got, input rank_out_t want);
        error_count++;
        if (error_count <= 40)
            $display("%0t mismatch %s: got num=%0d last=%0b ovf=%0b, want num=%0d last=%0b ovf=%0b",
                     $time, what, got.record_number, got.last, got.overflow,
                     want.record_number, want.last, want.overflow);
    endtask

    // strcmp-style order of two stored keys
    function automatic cmp_t key_order(input int unsigned ra, input int unsigned rb);
        logic [7:0] ca;
        logic [7:0] cb;
        for (int w = 0; w < KeyWords; w++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                ca = shadow_keys[ra*KeyWords+w][63-8*b -: 8];
                cb = shadow_keys[rb*KeyWords+w][63-8*b -: 8];
                if (ca != cb)
                    return (ca < cb) ? CMP_LT : CMP_GT;
                if (ca == 8'd0)
                    return CMP_EQ;
            end
        end
        return CMP_EQ;
    endfunction

    // sift-down over 1-based heap positions
    function automatic void sift_heap(input int unsigned top, input int unsigned n);
        logic [NumWidth-1:0] held;
        int unsigned c;
        held = shadow_heap[top-1];
        c = 2 * top;
        while (c <= n)
        begin
            if (c < n && key_order(shadow_heap[c-1], shadow_heap[c]) == CMP_LT)
                c++;
            if (key_order(held, shadow_heap[c-1]) == CMP_GT)
                break;
            shadow_heap[c/2-1] = shadow_heap[c-1];
            c = c * 2;
        end
        shadow_heap[c/2-1] = held;
    endfunction

    // next state and expected ranks for one accepted word; returns ranks queued
    function automatic int unsigned predict_ranks(input key_in_t w);
        int unsigned n;
        logic [NumWidth-1:0] t;
        rank_out_t r;
        if (shadow_count < MaxRec && shadow_pos < KeyWords)
            shadow_keys[shadow_count*KeyWords+shadow_pos] = w.key_word;
        if (shadow_pos < KeyWords)
            shadow_pos++;
        if (!(w.word_last || w.record_last))
            return 0;
        if (shadow_count < MaxRec)
        begin
            for (int k = shadow_pos; k < KeyWords; k++)
                shadow_keys[shadow_count*KeyWords+k] = '0;
            shadow_count++;
        end
        else
            shadow_ovf = 1'b1;
        shadow_pos = 0;
        if (!w.record_last)
            return 0;
        n = shadow_count;
        for (int i = 0; i < n; i++)
            shadow_heap[i] = NumWidth'(i);
        for (int i = n / 2; i > 0; i--)
            sift_heap(i, n);
        for (int i = n - 1; i > 0; i--)
        begin
            t = shadow_heap[0];
            shadow_heap[0] = shadow_heap[i];
            shadow_heap[i] = t;
            sift_heap(1, i);
        end
        for (int k = 0; k < n; k++)
        begin
            r.record_number = shadow_heap[k];
            r.last          = (k + 1 == n);
            r.overflow      = shadow_ovf;
            rank_q.push_back(r);
        end
        shadow_count = 0;
        shadow_ovf   = 1'b0;
        return n;
    endfunction

    // drive one word, holding valid across back-to-back words
    task automatic send_word(input logic [WordWidth-1:0] kw, input bit wl, input bit rl,
                             input bit typed, input rank_out_t typed_res);
        key_in_t w;
        int unsigned n;
        w.key_word    = kw;
        w.word_last   = wl;
        w.record_last = rl;
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n = predict_ranks(w);
        if (typed && n == 1)
        begin
            void'(rank_q.pop_back());
            rank_q.push_back(typed_res);
        end
    endtask

    // receiver with random back-pressure
    always @(posedge clk)
    begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (rank_q.size() == 0)
                report("unexpected word", out_ch.data, '0);
            else if (out_ch.data !== rank_q[0])
            begin
                report("wrong field", out_ch.data, rank_q[0]);
                void'(rank_q.pop_front());
            end
            else
                void'(rank_q.pop_front());
        end
    end

    // key bytes mostly from a small alphabet so that prefixes collide often, else random words
    function automatic logic [WordWidth-1:0] rand_key_word();
        logic [WordWidth-1:0] kw;
        logic [7:0] alphabet [4];
        alphabet = '{8'h00, 8'h61, 8'h62, 8'hFF};
        if ($urandom_range(2) == 0)
            kw = {$urandom, $urandom};
        else
            for (int b = 0; b < 8; b++)
                kw[8*b +: 8] = alphabet[$urandom_range(3)];
        return kw;
    endfunction

    task automatic set_idling(input int sent);
        if (sent < NumRandom / 3)
        begin
            send_idle = 32;
            recv_idle = 48;
        end
        else if (sent < 2 * NumRandom / 3)
        begin
            send_idle = 48;
            recv_idle = 32;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    function automatic row_t mk_row(input logic [WordWidth-1:0] kw, input bit wl, input bit rl,
                                    input bit typed = 1'b0, input logic [NumWidth-1:0] num = '0);
        row_t r;
        r.key_word    = kw;
        r.word_last   = wl;
        r.record_last = rl;
        r.typed       = typed;
        r.typed_res   = '{record_number: num, last: 1'b1, overflow: 1'b0};
        return r;
    endfunction

    // stimulus
    initial
    begin
        int sent;
        int batch_recs;
        int rec_words;
        int waited;
        rank_out_t none;

        none         = '0;
        error_count  = 0;
        shadow_count = 0;
        shadow_pos   = 0;
        shadow_ovf   = 1'b0;
        send_idle    = 32;
        recv_idle    = 48;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        // single records at the extremes, then ordering and padding cases
        dir_rows[0]  = mk_row(64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 1, 0);
        dir_rows[1]  = mk_row(64'h0, 1, 1, 1, 0);
        dir_rows[2]  = mk_row(64'h6200_0000_0000_0000, 1, 0);
        dir_rows[3]  = mk_row(64'h6100_0000_0000_0000, 1, 1);
        // zero byte inside a word hides the bytes after it
        dir_rows[4]  = mk_row(64'h4100_FFFF_FFFF_FFFF, 0, 0);
        dir_rows[5]  = mk_row(64'h0000_0000_0000_0001, 1, 0);
        dir_rows[6]  = mk_row(64'h4100_AAAA_AAAA_AAAA, 1, 0);
        // record_last alone closes the record
        dir_rows[7]  = mk_row(64'h4142_0000_0000_0000, 0, 1);
        // overlong key: words past the key length are dropped
        for (int i = 0; i < 8; i++)
            dir_rows[8+i] = mk_row(64'h6161_6161_6161_6161 + i, 0, 0);
        dir_rows[16] = mk_row(64'h7A7A_7A7A_7A7A_7A7A, 1, 0);
        // short key, zero padded
        dir_rows[17] = mk_row(64'h6161_6161_6161_6161, 1, 0);
        // top bit set compares as unsigned
        dir_rows[18] = mk_row(64'h8000_0000_0000_0000, 1, 0);
        dir_rows[19] = mk_row(64'h7FFF_FFFF_FFFF_FFFF, 1, 1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].key_word, dir_rows[i].word_last, dir_rows[i].record_last,
                      dir_rows[i].typed, dir_rows[i].typed_res);

        // hold off until the directed batches have drained
        in_ch.valid <= 1'b0;
        while (rank_q.size() != 0)
            @(posedge clk);

        // random batches: mostly small, a few near or past capacity
        sent = 0;
        while (sent < NumRandom)
        begin
            if ($urandom_range(9) == 0)
                batch_recs = $urandom_range(MaxRec + 3, MaxRec - 1);
            else
                batch_recs = $urandom_range(6, 1);
            for (int r = 0; r < batch_recs; r++)
            begin
                if ($urandom_range(9) == 0)
                    rec_words = $urandom_range(KeyWords + 2, KeyWords - 1);
                else
                    rec_words = $urandom_range(3, 1);
                for (int w = 0; w < rec_words; w++)
                begin
                    set_idling(sent);
                    send_word(rand_key_word(), (w == rec_words - 1) && ($urandom_range(7) != 0),
                              (r == batch_recs - 1) && (w == rec_words - 1), 1'b0, none);
                    sent++;
                end
            end
        end
        in_ch.valid <= 1'b0;

        waited = 0;
        while (rank_q.size() != 0 && waited < 200_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);

        if (error_count == 0 && rank_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
